// ===== rtl/kaa_pkg.sv =====
// Package for the keyed average accumulator.
// Field widths, table entry type, action codes, sequencer states and sizing defaults.
// Used by every file in rtl; depends on nothing.
package kaa_pkg;

    localparam int ACTION_W = 1;
    localparam int KEY_W = 11;
    localparam int RATING_W = 8;
    localparam int AVG_W = 12;
    localparam int COUNT_W = 20;
    localparam int SUM_W = 28;
    localparam int FRAC_SHIFT = 4;
    localparam int DIVIDEND_W = SUM_W + FRAC_SHIFT;
    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam int KEY_SPAN = 1 << KEY_W;
    localparam int NUM_KEYS_DEFAULT = 2048;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [AVG_W-1:0] AVG_MAX = '1;

    localparam logic [ACTION_W-1:0] ACT_ACCUMULATE = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [COUNT_W-1:0] count;
        logic sat;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DIVIDE,
        ST_LOAD
    } state_t;

endpackage

// ===== rtl/kaa_table.sv =====
// Per-key table of running sum, count and saturation mark.
// One write port and one read port with registered read data.
// Depends on kaa_pkg for the entry type.
module kaa_table
    import kaa_pkg::*;
#(
    parameter int DEPTH = NUM_KEYS_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t table_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/kaa_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
// Divides the scaled sum by the count and clamps the quotient to the average width.
// Depends on kaa_pkg for widths.
module kaa_divider
    import kaa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [COUNT_W-1:0]    divisor,
    output logic                  done,
    output logic [AVG_W-1:0]      quotient
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [COUNT_W:0]      rem_reg;
    logic [COUNT_W:0]      rem_next;
    logic [COUNT_W-1:0]    div_reg;
    logic [COUNT_W-1:0]    div_next;
    logic [COUNT_W:0]      rem_shift;
    logic                  ge;

    assign rem_shift = {rem_reg[COUNT_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign ge = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? (rem_shift - {1'b0, div_reg}) : rem_shift;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quotient = (|quo_reg[DIVIDEND_W-1:AVG_W]) ? AVG_MAX : quo_reg[AVG_W-1:0];

endmodule

// ===== rtl/keyed_average_accumulator.sv =====
// Top level of the keyed average accumulator: sequencer, update logic and result register.
// Instantiates kaa_table and kaa_divider; depends on kaa_pkg.
//
//   channel  beat                          handshake
//   item     action, key, rating           item_valid / item_stall
//   result   average, sample_count, saturated  result_valid / result_stall
//
// After reset all min(NUM_KEYS, 2048) table entries are zeroed with item_stall high.
// An accumulate reads the table entry, then writes the saturating update back.
// A query goes through table read, divider start, 32 divider steps, quotient capture and
// one load into the result register; a key with no ratings skips the divider.
// An out-of-range accumulate is dropped; an out-of-range query goes straight to load.
// A stalled result holds the result register; accumulates go on, the next query waits at load.
module keyed_average_accumulator
    import kaa_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [KEY_W-1:0]    key,
    input  logic [RATING_W-1:0] rating,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [AVG_W-1:0]    average,
    output logic [COUNT_W-1:0]  sample_count,
    output logic                saturated
);

    localparam int DEPTH = (NUM_KEYS < KEY_SPAN) ? NUM_KEYS : KEY_SPAN;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg;
    state_t state_next;

    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       clr_addr_next;
    logic [ACTION_W-1:0] action_reg;
    logic [ACTION_W-1:0] action_next;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       addr_next;
    logic [RATING_W-1:0] rating_reg;
    logic [RATING_W-1:0] rating_next;
    logic [AVG_W-1:0]    res_avg_reg;
    logic [AVG_W-1:0]    res_avg_next;
    logic [COUNT_W-1:0]  res_count_reg;
    logic [COUNT_W-1:0]  res_count_next;
    logic                res_sat_reg;
    logic                res_sat_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [AVG_W-1:0]    average_reg;
    logic [AVG_W-1:0]    average_next;
    logic [COUNT_W-1:0]  sample_count_reg;
    logic [COUNT_W-1:0]  sample_count_next;
    logic                saturated_reg;
    logic                saturated_next;

    logic                item_accept;
    logic                key_in_range;
    logic                out_free;
    logic                load_result;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    entry_t              rd_data;
    entry_t              upd_entry;
    logic [SUM_W:0]      sum_wide;
    logic                div_start;
    logic                div_done;
    logic [AVG_W-1:0]    div_quotient;

    assign item_stall = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign key_in_range = {{(32 - KEY_W){1'b0}}, key} < 32'(NUM_KEYS);
    assign out_free = !out_valid_reg || !result_stall;
    assign load_result = (state_reg == ST_LOAD) && out_free;

    kaa_table #(
        .DEPTH(DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (item_accept),
        .rd_addr(key[AW-1:0]),
        .rd_data(rd_data)
    );

    kaa_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend({rd_data.sum, {FRAC_SHIFT{1'b0}}}),
        .divisor (rd_data.count),
        .done    (div_done),
        .quotient(div_quotient)
    );

    assign sum_wide = {1'b0, rd_data.sum} + {{(SUM_W + 1 - RATING_W){1'b0}}, rating_reg};

    always_comb
    begin
        upd_entry.sum = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        upd_entry.count = (rd_data.count == COUNT_MAX) ? COUNT_MAX : (rd_data.count + 1'b1);
        upd_entry.sat = rd_data.sat || sum_wide[SUM_W] || (rd_data.count == COUNT_MAX);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (key_in_range)
                    begin
                        state_next = ST_LOOKUP;
                    end
                    else if (action == ACT_QUERY)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (action_reg == ACT_ACCUMULATE)
                begin
                    state_next = ST_IDLE;
                end
                else if (rd_data.count == '0)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        action_next = action_reg;
        addr_next = addr_reg;
        rating_next = rating_reg;
        res_avg_next = res_avg_reg;
        res_count_next = res_count_reg;
        res_sat_next = res_sat_reg;
        wr_en = 1'b0;
        wr_addr = addr_reg;
        wr_data = upd_entry;
        div_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    action_next = action;
                    addr_next = key[AW-1:0];
                    rating_next = rating;
                    res_avg_next = '0;
                    res_count_next = '0;
                    res_sat_next = 1'b1;
                end
            end
            ST_LOOKUP:
            begin
                if (action_reg == ACT_ACCUMULATE)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    res_avg_next = '0;
                    res_count_next = rd_data.count;
                    res_sat_next = rd_data.sat;
                    div_start = (rd_data.count != '0);
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_avg_next = div_quotient;
                end
            end
            ST_LOAD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        average_next = average_reg;
        sample_count_next = sample_count_reg;
        saturated_next = saturated_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
            average_next = res_avg_reg;
            sample_count_next = res_count_reg;
            saturated_next = res_sat_reg;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_addr_reg <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        addr_reg <= addr_next;
        rating_reg <= rating_next;
        res_avg_reg <= res_avg_next;
        res_count_reg <= res_count_next;
        res_sat_reg <= res_sat_next;
        average_reg <= average_next;
        sample_count_reg <= sample_count_next;
        saturated_reg <= saturated_next;
    end

    assign result_valid = out_valid_reg;
    assign average = average_reg;
    assign sample_count = sample_count_reg;
    assign saturated = saturated_reg;

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    a_lookup_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> ($past(state_reg) == ST_IDLE))
        else $error("table lookup not preceded by an accepted beat");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (result_valid && (average == $past(res_avg_reg))))
        else $error("loaded result not presented");

    a_no_write_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOOKUP) && (action_reg == ACT_QUERY)) |-> !wr_en)
        else $error("query wrote the table");

endmodule
